>>> hdl/rpcd_pkg.sv
// ----------------------------------------------------------------------------
// rpcd_pkg
// shared constants of the point to ray distance core
// ----------------------------------------------------------------------------
`default_nettype none

package rpcd_pkg;

	// coordinate word and fraction defaults (signed q16.16)
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// request kinds
	localparam logic REQ_CLOSEST = 1'b0;
	localparam logic REQ_GIVEN   = 1'b1;

endpackage

`default_nettype wire

>>> hdl/rpcd_if.sv
// ----------------------------------------------------------------------------
// rpcd channel interfaces
// query and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface rpcd_query_if #(
	parameter int COORD_WIDTH = rpcd_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [COORD_WIDTH-1:0] support_x;
	logic signed [COORD_WIDTH-1:0] support_y;
	logic signed [COORD_WIDTH-1:0] support_z;
	logic signed [COORD_WIDTH-1:0] dir_x;
	logic signed [COORD_WIDTH-1:0] dir_y;
	logic signed [COORD_WIDTH-1:0] dir_z;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic signed [COORD_WIDTH-1:0] given_param;

	modport source (
		output valid, req_type, support_x, support_y, support_z,
		       dir_x, dir_y, dir_z, point_x, point_y, point_z, given_param,
		input  ready
	);
	modport sink (
		input  valid, req_type, support_x, support_y, support_z,
		       dir_x, dir_y, dir_z, point_x, point_y, point_z, given_param,
		output ready
	);
endinterface

interface rpcd_result_if #(
	parameter int COORD_WIDTH = rpcd_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] ray_param;
	logic        [COORD_WIDTH-1:0] distance;
	logic                          zero_direction;
	logic                          overflow;

	modport source (
		output valid, ray_param, distance, zero_direction, overflow,
		input  ready
	);
	modport sink (
		input  valid, ray_param, distance, zero_direction, overflow,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/ray_point_closest_distance_core.sv
// ----------------------------------------------------------------------------
// ray_point_closest_distance_core
// closest ray parameter and point to ray distance in signed fixed point
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------
//  query   | in  | req_type, support_xyz, dir_xyz, point_xyz, given_param
//  result  | out | ray_param, distance, zero_direction, overflow
//
//  one beat per cycle is taken and given unless the result stalls; the pipe depth
//  is set by the division row (one quotient bit per cell) and the square root
//  row (one root bit per cell).
//  arst_n clears all valid flags; payload registers are not reset.
//  the whole pipe advances together; a stalled result freezes every stage,
//  and query.ready is low only while the output register is full and held.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_point_closest_distance_core #(
	parameter int COORD_WIDTH = rpcd_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rpcd_pkg::FRAC_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rpcd_query_if.sink    query,
	rpcd_result_if.source result
);

	localparam int CW   = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int DW   = CW + 1;          // p - s
	localparam int PRW  = 2 * CW + 1;      // d * (p - s)
	localparam int NW   = 2 * CW + 3;      // numerator
	localparam int MW   = 2 * CW + 2;      // numerator magnitude
	localparam int CMPW = 2 * CW + F + 2;  // overflow compare width
	localparam int WW   = 2 * CW + 1;      // residual component
	localparam int QW   = 4 * CW;          // squared component
	localparam int SW   = 4 * CW + 2;      // sum of squares
	// division payload: req, given, neg, zero, ovf_hi, diff x3, dir x3
	localparam int DPW  = 1 + CW + 3 + 3 * DW + 3 * CW;
	// square root payload: t, zero, ovf_t, ovf_d
	localparam int SPW  = CW + 3;

	logic en;

	// --------------------------------------------------------------------
	// input unpack
	// --------------------------------------------------------------------
	logic signed [CW-1:0] sup_in [3];
	logic signed [CW-1:0] dir_in [3];
	logic signed [CW-1:0] pnt_in [3];

	assign sup_in[0] = query.support_x;
	assign sup_in[1] = query.support_y;
	assign sup_in[2] = query.support_z;
	assign dir_in[0] = query.dir_x;
	assign dir_in[1] = query.dir_y;
	assign dir_in[2] = query.dir_z;
	assign pnt_in[0] = query.point_x;
	assign pnt_in[1] = query.point_y;
	assign pnt_in[2] = query.point_z;

	// --------------------------------------------------------------------
	// stage 1: p - s
	// --------------------------------------------------------------------
	logic                 v_s1, req_s1;
	logic signed [CW-1:0] given_s1;
	logic signed [CW-1:0] d_s1    [3];
	logic signed [DW-1:0] diff_s1 [3];

	// --------------------------------------------------------------------
	// stage 2: products d.d and d.(p - s)
	// --------------------------------------------------------------------
	logic                  v_s2, req_s2;
	logic signed [CW-1:0]  given_s2;
	logic signed [CW-1:0]  d_s2    [3];
	logic signed [DW-1:0]  diff_s2 [3];
	logic [2*CW-1:0]       dd_s2   [3];
	logic signed [PRW-1:0] dp_s2   [3];

	// --------------------------------------------------------------------
	// stage 3: dot sums
	// --------------------------------------------------------------------
	logic                 v_s3, req_s3;
	logic signed [CW-1:0] given_s3;
	logic signed [CW-1:0] d_s3    [3];
	logic signed [DW-1:0] diff_s3 [3];
	logic [2*CW-1:0]      den_s3;
	logic signed [NW-1:0] num_s3;

	// --------------------------------------------------------------------
	// stage 4: sign, magnitude, zero direction
	// --------------------------------------------------------------------
	logic                 v_s4, req_s4, neg_s4, zero_s4;
	logic signed [CW-1:0] given_s4;
	logic signed [CW-1:0] d_s4    [3];
	logic signed [DW-1:0] diff_s4 [3];
	logic [2*CW-1:0]      den_s4;
	logic [MW-1:0]        mag_s4;
	logic signed [NW-1:0] num_neg;

	// --------------------------------------------------------------------
	// stage 5: quotient range check and division seed
	// --------------------------------------------------------------------
	logic [CMPW-1:0] hi_ext;
	logic            ovfh_c;

	// division row, index 0 is stage 5
	logic            dv    [CW+1];
	logic [2*CW-1:0] drem  [CW+1];
	logic [2*CW-1:0] dden  [CW+1];
	logic [CW-1:0]   dlow  [CW+1];
	logic [CW-1:0]   dquo  [CW+1];
	logic [DPW-1:0]  dpay  [CW+1];

	// division row output unpack
	logic                 req_o, given_neg_o, zero_o, ovfh_o;
	logic signed [CW-1:0] given_o;
	logic signed [DW-1:0] diff_o [3];
	logic signed [CW-1:0] d_o    [3];

	// --------------------------------------------------------------------
	// stage 6: ray parameter with saturation
	// --------------------------------------------------------------------
	logic                 v_s6, zero_s6, ovft_s6;
	logic signed [CW-1:0] t_s6;
	logic signed [CW-1:0] d_s6    [3];
	logic signed [DW-1:0] diff_s6 [3];
	logic signed [CW-1:0] t_c;
	logic                 ovft_c, zero_c;

	// stage 7: d * t
	logic                   v_s7, zero_s7, ovft_s7;
	logic signed [CW-1:0]   t_s7;
	logic signed [DW-1:0]   diff_s7 [3];
	logic signed [2*CW-1:0] dt_s7   [3];

	// stage 8: residual magnitude
	logic                 v_s8, zero_s8, ovft_s8;
	logic signed [CW-1:0] t_s8;
	logic [2*CW-1:0]      aw_s8 [3];
	logic signed [WW-1:0] w_c   [3];

	// stage 9: partial products of the square
	logic                 v_s9, zero_s9, ovft_s9;
	logic signed [CW-1:0] t_s9;
	logic [2*CW-1:0]      a2_s9 [3];
	logic [2*CW-1:0]      ab_s9 [3];
	logic [2*CW-1:0]      b2_s9 [3];

	// stage 10: squared components
	logic                 v_s10, zero_s10, ovft_s10;
	logic signed [CW-1:0] t_s10;
	logic [QW-1:0]        sq_s10 [3];

	// stage 11: sum of squares, drop fraction, range check
	logic [SW-1:0]        sum_c;

	// square root row, index 0 is stage 11
	logic            sv    [CW+1];
	logic [2*CW-1:0] sopnd [CW+1];
	logic [CW+1:0]   srem  [CW+1];
	logic [CW-1:0]   sroot [CW+1];
	logic [SPW-1:0]  spay  [CW+1];

	// output register
	logic                 v_q;
	logic signed [CW-1:0] ray_param_q;
	logic [CW-1:0]        distance_q;
	logic                 zero_direction_q;
	logic                 overflow_q;
	logic signed [CW-1:0] t_fin;
	logic                 zero_fin, ovft_fin, ovfd_fin;

	// whole pipe moves unless the output holds an untaken result
	assign en          = !v_q || result.ready;
	assign query.ready = en;

	// --------------------------------------------------------------------
	// valid chain (front and back stages)
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			dv[0] <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			sv[0] <= 1'b0;
			v_q   <= 1'b0;
		end else if (en) begin
			v_s1  <= query.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			dv[0] <= v_s4;
			v_s6  <= dv[CW];
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			sv[0] <= v_s10;
			v_q   <= sv[CW];
		end
	end

	// --------------------------------------------------------------------
	// front: up to the division seed
	// --------------------------------------------------------------------
	assign num_neg = -num_s3;

	always_comb begin
		hi_ext = CMPW'(mag_s4[MW-1:CW-F]);
		ovfh_c = hi_ext >= CMPW'(den_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			req_s1   <= query.req_type;
			given_s1 <= query.given_param;
			for (int i = 0; i < 3; i++) begin
				d_s1[i]    <= dir_in[i];
				diff_s1[i] <= DW'(pnt_in[i]) - DW'(sup_in[i]);
			end
			// stage 2
			req_s2   <= req_s1;
			given_s2 <= given_s1;
			for (int i = 0; i < 3; i++) begin
				d_s2[i]    <= d_s1[i];
				diff_s2[i] <= diff_s1[i];
				dd_s2[i]   <= (2*CW)'(d_s1[i] * d_s1[i]);
				dp_s2[i]   <= PRW'(d_s1[i] * diff_s1[i]);
			end
			// stage 3
			req_s3   <= req_s2;
			given_s3 <= given_s2;
			d_s3     <= d_s2;
			diff_s3  <= diff_s2;
			den_s3   <= dd_s2[0] + dd_s2[1] + dd_s2[2];
			num_s3   <= NW'(dp_s2[0]) + NW'(dp_s2[1]) + NW'(dp_s2[2]);
			// stage 4
			req_s4   <= req_s3;
			given_s4 <= given_s3;
			d_s4     <= d_s3;
			diff_s4  <= diff_s3;
			den_s4   <= den_s3;
			neg_s4   <= num_s3[NW-1];
			mag_s4   <= num_s3[NW-1] ? num_neg[MW-1:0] : num_s3[MW-1:0];
			zero_s4  <= den_s3 == '0;
			// stage 5, seeds the division row
			drem[0]  <= hi_ext[2*CW-1:0];
			dden[0]  <= den_s4;
			dlow[0]  <= {mag_s4[CW-F-1:0], {F{1'b0}}};
			dquo[0]  <= '0;
			dpay[0]  <= {req_s4, given_s4, neg_s4, zero_s4, ovfh_c,
			             diff_s4[0], diff_s4[1], diff_s4[2],
			             d_s4[0], d_s4[1], d_s4[2]};
		end
	end

	// --------------------------------------------------------------------
	// division row: one quotient bit per cell
	// --------------------------------------------------------------------
	for (genvar k = 0; k < CW; k++) begin : g_div
		rpcd_div_cell #(
			.RW (2 * CW),
			.LW (CW),
			.PW (DPW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv[k]),
			.in_rem    (drem[k]),
			.in_den    (dden[k]),
			.in_low    (dlow[k]),
			.in_quo    (dquo[k]),
			.in_pay    (dpay[k]),
			.out_valid (dv[k+1]),
			.out_rem   (drem[k+1]),
			.out_den   (dden[k+1]),
			.out_low   (dlow[k+1]),
			.out_quo   (dquo[k+1]),
			.out_pay   (dpay[k+1])
		);
	end

	assign {req_o, given_o, given_neg_o, zero_o, ovfh_o,
	        diff_o[0], diff_o[1], diff_o[2],
	        d_o[0], d_o[1], d_o[2]} = dpay[CW];

	// ray parameter: given, zero direction, or saturated signed quotient
	always_comb begin
		t_c    = '0;
		ovft_c = 1'b0;
		zero_c = 1'b0;
		if (req_o == rpcd_pkg::REQ_GIVEN) begin
			t_c = given_o;
		end else if (zero_o) begin
			zero_c = 1'b1;
		end else if (!given_neg_o) begin
			ovft_c = ovfh_o || dquo[CW][CW-1];
			t_c    = ovft_c ? {1'b0, {(CW-1){1'b1}}} : dquo[CW];
		end else begin
			ovft_c = ovfh_o || (dquo[CW][CW-1] && (|dquo[CW][CW-2:0]));
			t_c    = ovft_c ? {1'b1, {(CW-1){1'b0}}} : -dquo[CW];
		end
	end

	// --------------------------------------------------------------------
	// back: position and squared residual
	// --------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w_c[i] = (WW'(diff_s7[i]) <<< F) - WW'(dt_s7[i]);
		end
		sum_c = SW'(sq_s10[0]) + SW'(sq_s10[1]) + SW'(sq_s10[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 6
			t_s6    <= t_c;
			zero_s6 <= zero_c;
			ovft_s6 <= ovft_c;
			d_s6    <= d_o;
			diff_s6 <= diff_o;
			// stage 7
			t_s7    <= t_s6;
			zero_s7 <= zero_s6;
			ovft_s7 <= ovft_s6;
			diff_s7 <= diff_s6;
			for (int i = 0; i < 3; i++) begin
				dt_s7[i] <= (2*CW)'(d_s6[i] * t_s6);
			end
			// stage 8
			t_s8    <= t_s7;
			zero_s8 <= zero_s7;
			ovft_s8 <= ovft_s7;
			for (int i = 0; i < 3; i++) begin
				aw_s8[i] <= w_c[i][WW-1] ? (2*CW)'(-w_c[i]) : w_c[i][2*CW-1:0];
			end
			// stage 9, split each magnitude in halves
			t_s9    <= t_s8;
			zero_s9 <= zero_s8;
			ovft_s9 <= ovft_s8;
			for (int i = 0; i < 3; i++) begin
				a2_s9[i] <= aw_s8[i][2*CW-1:CW] * aw_s8[i][2*CW-1:CW];
				ab_s9[i] <= aw_s8[i][2*CW-1:CW] * aw_s8[i][CW-1:0];
				b2_s9[i] <= aw_s8[i][CW-1:0] * aw_s8[i][CW-1:0];
			end
			// stage 10
			t_s10    <= t_s9;
			zero_s10 <= zero_s9;
			ovft_s10 <= ovft_s9;
			for (int i = 0; i < 3; i++) begin
				sq_s10[i] <= (QW'(a2_s9[i]) << (2 * CW)) + (QW'(ab_s9[i]) << (CW + 1))
				             + QW'(b2_s9[i]);
			end
			// stage 11, seeds the root row
			sopnd[0] <= sum_c[2*CW+2*F-1:2*F];
			srem[0]  <= '0;
			sroot[0] <= '0;
			spay[0]  <= {t_s10, zero_s10, ovft_s10, |sum_c[SW-1:2*CW+2*F]};
		end
	end

	// --------------------------------------------------------------------
	// square root row: one root bit per cell
	// --------------------------------------------------------------------
	for (genvar k = 0; k < CW; k++) begin : g_sqrt
		rpcd_sqrt_cell #(
			.RW (CW),
			.PW (SPW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sv[k]),
			.in_opnd   (sopnd[k]),
			.in_rem    (srem[k]),
			.in_root   (sroot[k]),
			.in_pay    (spay[k]),
			.out_valid (sv[k+1]),
			.out_opnd  (sopnd[k+1]),
			.out_rem   (srem[k+1]),
			.out_root  (sroot[k+1]),
			.out_pay   (spay[k+1])
		);
	end

	assign {t_fin, zero_fin, ovft_fin, ovfd_fin} = spay[CW];

	// --------------------------------------------------------------------
	// output register
	// --------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			ray_param_q      <= t_fin;
			distance_q       <= ovfd_fin ? {CW{1'b1}} : sroot[CW];
			zero_direction_q <= zero_fin;
			overflow_q       <= ovft_fin || ovfd_fin;
		end
	end

	assign result.valid          = v_q;
	assign result.ray_param      = ray_param_q;
	assign result.distance       = distance_q;
	assign result.zero_direction = zero_direction_q;
	assign result.overflow       = overflow_q;

endmodule

`default_nettype wire

>>> hdl/rpcd_div_cell.sv
// ----------------------------------------------------------------------------
// rpcd_div_cell
// one restoring division step, one quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module rpcd_div_cell #(
	parameter int RW = 64,
	parameter int LW = 32,
	parameter int PW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [RW-1:0] in_rem,
	input  wire logic [RW-1:0] in_den,
	input  wire logic [LW-1:0] in_low,
	input  wire logic [LW-1:0] in_quo,
	input  wire logic [PW-1:0] in_pay,
	output logic               out_valid,
	output logic      [RW-1:0] out_rem,
	output logic      [RW-1:0] out_den,
	output logic      [LW-1:0] out_low,
	output logic      [LW-1:0] out_quo,
	output logic      [PW-1:0] out_pay
);

	logic [RW:0]   rem_ext;
	logic [RW:0]   rem_sub;
	logic          ge;
	logic [RW-1:0] rem_nxt;

	always_comb begin
		rem_ext = {in_rem, in_low[LW-1]};
		rem_sub = rem_ext - {1'b0, in_den};
		ge      = rem_ext >= {1'b0, in_den};
		rem_nxt = ge ? rem_sub[RW-1:0] : rem_ext[RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem <= rem_nxt;
			out_den <= in_den;
			out_low <= {in_low[LW-2:0], 1'b0};
			out_quo <= {in_quo[LW-2:0], ge};
			out_pay <= in_pay;
		end
	end

endmodule

`default_nettype wire

>>> hdl/rpcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rpcd_sqrt_cell
// one digit-by-digit square root step, one root bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module rpcd_sqrt_cell #(
	parameter int RW = 32,
	parameter int PW = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [2*RW-1:0] in_opnd,
	input  wire logic [RW+1:0]   in_rem,
	input  wire logic [RW-1:0]   in_root,
	input  wire logic [PW-1:0]   in_pay,
	output logic                 out_valid,
	output logic      [2*RW-1:0] out_opnd,
	output logic      [RW+1:0]   out_rem,
	output logic      [RW-1:0]   out_root,
	output logic      [PW-1:0]   out_pay
);

	logic [RW+3:0] rem_ext;
	logic [RW+3:0] trial;
	logic [RW+3:0] rem_sub;
	logic          ge;

	always_comb begin
		rem_ext = {in_rem, in_opnd[2*RW-1 -: 2]};
		trial   = {2'b00, in_root, 2'b01};
		rem_sub = rem_ext - trial;
		ge      = rem_ext >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_opnd <= {in_opnd[2*RW-3:0], 2'b00};
			out_rem  <= ge ? rem_sub[RW+1:0] : rem_ext[RW+1:0];
			out_root <= {in_root[RW-2:0], ge};
			out_pay  <= in_pay;
		end
	end

endmodule

`default_nettype wire
